### rtl/spq_pkg.sv
// Shared types, sizes and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0]        count_type;

   // request actions
   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_PEEK   = 2'd3;

   // response status
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      value_type  key;
   } cell_ctl_type;

endpackage
`default_nettype wire

### rtl/spq_cell.sv
// One storage cell of the sorted row: compares against the key and shifts with its neighbours.
`default_nettype none
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                 occupied,
   input  spq_pkg::value_type   left_value,
   input  spq_pkg::value_type   right_value,
   input  logic                 left_le,
   output logic                 le,
   input  logic                 seen_in,
   output logic                 seen_out,
   output spq_pkg::value_type   value
);
   import spq_pkg::*;

   value_type value_ff, value_in;

   assign le       = occupied && (value_ff <= ctl.key);
   assign seen_out = seen_in || (occupied && (value_ff == ctl.key));
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            // keep entries not above the key, take the key at the boundary, shift the rest right
            if (le) begin
               value_in = value_ff;
            end else if (left_le) begin
               value_in = ctl.key;
            end else begin
               value_in = left_value;
            end
         end
         CELL_DELETE: begin
            if (seen_out) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of compare-and-shift cells with a small sequencer.
// Push, pop, peek, and remove on an empty queue: the accepted request moves the sequencer from idle
// to the report state, which loads the output register and returns to idle. Remove otherwise passes
// through the remove state, one gap closed per cycle, then a step that finds none left, then report.
// A result not yet taken holds the sequencer; the output register keeps it while the next is taken.
// Reset empties the queue (count zero) and drops any pending result; stored values are not cleared.
`default_nettype none
module sorted_priority_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_front_value,
   output logic                        rsp_is_empty,
   output logic [4:0]                  rsp_fill_count,
   output logic [4:0]                  rsp_removed_count,
   output logic [1:0]                  rsp_status
);
   import spq_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REMOVE = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   logic [1:0]   state_ff, state_in;
   count_type    count_ff, count_in;
   count_type    removed_ff, removed_in;
   logic [1:0]   status_ff, status_in;
   value_type    key_ff, key_in;

   logic         rsp_valid_ff, rsp_valid_in;
   value_type    front_ff, front_in;
   logic         empty_ff, empty_in;
   count_type    fill_ff, fill_in;
   count_type    rem_ff, rem_in;
   logic [1:0]   stat_ff, stat_in;

   cell_ctl_type ctl;
   logic         pop_seed;
   logic         accept;
   logic         out_free;
   logic         full;
   logic         match;

   value_type    cell_value [DEPTH];
   logic [DEPTH-1:0] occupied;
   logic [DEPTH-1:0] le;
   logic [DEPTH-1:0] seen;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == count_type'(DEPTH));
   assign match     = seen[DEPTH-1];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         value_type left_v, right_v;
         logic      left_le_v, seen_in_v;

         assign occupied[g] = (count_type'(g) < count_ff);

         if (g == 0) begin : g_first
            assign left_v    = ctl.key;
            assign left_le_v = 1'b1;
            assign seen_in_v = pop_seed;
         end else begin : g_inner
            assign left_v    = cell_value[g-1];
            assign left_le_v = le[g-1];
            assign seen_in_v = seen[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign right_v = cell_value[g];
         end else begin : g_mid
            assign right_v = cell_value[g+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occupied[g]),
            .left_value  (left_v),
            .right_value (right_v),
            .left_le     (left_le_v),
            .le          (le[g]),
            .seen_in     (seen_in_v),
            .seen_out    (seen[g]),
            .value       (cell_value[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      key_in     = key_ff;
      ctl.op     = CELL_HOLD;
      ctl.key    = key_ff;
      pop_seed   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      front_in     = front_ff;
      empty_in     = empty_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      stat_in      = stat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.key    = req_value;
               key_in     = req_value;
               removed_in = '0;
               status_in  = STATUS_OK;
               state_in   = ST_REPORT;
               case (req_action)
                  ACT_PUSH: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        count_in = count_ff + count_type'(1);
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        // seed the delete chain so the whole row shifts down by one
                        ctl.op     = CELL_DELETE;
                        pop_seed   = 1'b1;
                        count_in   = count_ff - count_type'(1);
                        removed_in = count_type'(1);
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_REMOVE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_REMOVE: begin
            // drop one matching entry per beat until none is left
            ctl.op = CELL_DELETE;
            if (match) begin
               count_in   = count_ff - count_type'(1);
               removed_in = removed_ff + count_type'(1);
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               front_in     = (count_ff == '0) ? value_type'(-1) : cell_value[0];
               empty_in     = (count_ff == '0);
               fill_in      = count_ff;
               rem_in       = removed_ff;
               stat_in      = status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      status_ff  <= status_in;
      key_ff     <= key_in;
      front_ff   <= front_in;
      empty_ff   <= empty_in;
      fill_ff    <= fill_in;
      rem_ff     <= rem_in;
      stat_ff    <= stat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_front_value   = front_ff;
   assign rsp_is_empty      = empty_ff;
   assign rsp_fill_count    = fill_ff;
   assign rsp_removed_count = rem_ff;
   assign rsp_status        = stat_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_PUSH && !full) |=> count_ff == $past(count_ff) + count_type'(1))
      else $error("push did not grow the queue");

   a_remove_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE && match) |=>
         (count_ff == $past(count_ff) - count_type'(1) && state_ff == ST_REMOVE))
      else $error("remove step did not drop one entry");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (fill_ff == '0)))
      else $error("empty flag disagrees with fill count");

   a_report_after_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE && !match) |=> state_ff == ST_REPORT)
      else $error("remove did not finish");

endmodule
`default_nettype wire

### tb/sv/tb_sorted_priority_queue.sv
// Testbench for the sorted priority queue: random and directed actions checked against a predictor.
`timescale 1ns / 1ps
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int        STALL_LIMIT  = 2000;
   localparam int        HOLD_CYCLES  = 300;
   localparam int        PHASE_ITEMS  = 658;
   localparam value_type VAL_MIN      = 32'h8000_0000;
   localparam value_type VAL_MAX      = 32'h7fff_ffff;

   typedef struct {
      value_type  front;
      logic       is_empty;
      count_type  fill;
      count_type  removed;
      logic [1:0] status;
   } spq_result_type;

   // Keeps its own sorted copy of the store and the results still owed by the block.
   class spq_scoreboard_type;
      value_type      sorted_vals[DEPTH];
      int             occupancy;
      spq_result_type pending_results[$];
      int             errors;

      function new();
         occupancy = 0;
         errors    = 0;
      endfunction

      // Apply one accepted action to the sorted copy and queue the result it owes.
      function void note_request(logic [1:0] action, value_type val);
         spq_result_type res;
         int             pos;
         int             w;
         res.removed = '0;
         res.status  = STATUS_OK;
         case (action)
            ACT_PUSH: begin
               if (occupancy >= DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  pos = 0;
                  while (pos < occupancy && sorted_vals[pos] <= val) pos++;
                  for (int i = occupancy; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
                  sorted_vals[pos] = val;
                  occupancy++;
               end
            end
            ACT_POP: begin
               if (occupancy == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  for (int i = 0; i + 1 < occupancy; i++) sorted_vals[i] = sorted_vals[i+1];
                  occupancy--;
                  res.removed = count_type'(1);
               end
            end
            ACT_REMOVE: begin
               if (occupancy == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  w = 0;
                  for (int i = 0; i < occupancy; i++) begin
                     if (sorted_vals[i] == val) begin
                        res.removed++;
                     end else begin
                        sorted_vals[w] = sorted_vals[i];
                        w++;
                     end
                  end
                  occupancy = w;
               end
            end
            default: ;
         endcase
         res.front    = (occupancy == 0) ? -32'sd1 : sorted_vals[0];
         res.is_empty = (occupancy == 0);
         res.fill     = count_type'(occupancy);
         pending_results.insert(pending_results.size(), res);
      endfunction

      function void check_response(spq_result_type got);
         spq_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, front_value %0d", $time, got.front);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.front !== want.front) begin
            $display("%0t: front_value expected %0d, actual %0d", $time, want.front, got.front);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0d, actual %0d", $time, want.is_empty,
                     got.is_empty);
            errors++;
         end
         if (got.fill !== want.fill) begin
            $display("%0t: fill_count expected %0d, actual %0d", $time, want.fill, got.fill);
            errors++;
         end
         if (got.removed !== want.removed) begin
            $display("%0t: removed_count expected %0d, actual %0d", $time, want.removed,
                     got.removed);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction

      function value_type pick_stored();
         return sorted_vals[$urandom_range(0, occupancy - 1)];
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_action;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [31:0] rsp_front_value;
   logic              rsp_is_empty;
   logic [4:0]        rsp_fill_count;
   logic [4:0]        rsp_removed_count;
   logic [1:0]        rsp_status;

   spq_scoreboard_type board;
   int                 send_idle_pct;
   int                 rsp_idle_pct;
   logic               hold_off_req;
   int                 stall_cycles;

   sorted_priority_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_front_value  (rsp_front_value),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_removed_count(rsp_removed_count),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: check each beat, then decide ready for the next edge.
   initial begin : rsp_side
      int             hold_left;
      bit             hold_done;
      spq_result_type got;
      hold_left = 0;
      hold_done = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.front    = rsp_front_value;
            got.is_empty = rsp_is_empty;
            got.fill     = rsp_fill_count;
            got.removed  = rsp_removed_count;
            got.status   = rsp_status;
            board.check_response(got);
         end
         if (hold_off_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: count cycles with no beat on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] action, input value_type val);
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(action, val);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   // Hold the request side until the block owes nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_action(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0:       return r < 70 ? ACT_PUSH : r < 80 ? ACT_POP : r < 90 ? ACT_REMOVE : ACT_PEEK;
         1:       return r < 15 ? ACT_PUSH : r < 60 ? ACT_POP : r < 90 ? ACT_REMOVE : ACT_PEEK;
         default: return r < 35 ? ACT_PUSH : r < 60 ? ACT_POP : r < 85 ? ACT_REMOVE : ACT_PEEK;
      endcase
   endfunction

   function automatic value_type pick_value(logic [1:0] action);
      int r;
      r = $urandom_range(0, 99);
      if (action == ACT_REMOVE && board.occupancy > 0 && r < 70) return board.pick_stored();
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 8) - 4;
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic run_random(input int count);
      int         mode;
      logic [1:0] action;
      mode = 2;
      for (int n = 0; n < count; n++) begin
         // switch between filling, draining and a balanced mix
         if (n % 40 == 0) mode = $urandom_range(0, 2);
         action = pick_action(mode);
         send_item(action, pick_value(action));
      end
   endtask

   initial begin
      board         = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_action   <= ACT_PEEK;
      req_value    <= '0;
      hold_off_req <= 1'b0;
      send_idle_pct = 24;
      rsp_idle_pct  = 79;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty store, full store, removal of every entry, extremes, no-match remove
      send_item(ACT_POP, $urandom);
      send_item(ACT_REMOVE, 9);
      send_item(ACT_PEEK, $urandom);
      repeat (DEPTH) send_item(ACT_PUSH, 9);
      send_item(ACT_PUSH, VAL_MIN);
      send_item(ACT_REMOVE, 9);
      send_item(ACT_PUSH, VAL_MAX);
      send_item(ACT_PUSH, VAL_MIN);
      send_item(ACT_REMOVE, 0);
      send_item(ACT_POP, $urandom);
      send_item(ACT_REMOVE, VAL_MAX);
      wait_drained();

      run_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 79;
      rsp_idle_pct  = 24;
      run_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_off_req <= 1'b1;
      run_random(PHASE_ITEMS);
      wait_drained();

      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
